[src/npt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAT port translator package
// Shared sizes, codes and the search token that travels along the cell chain.
// ----------------------------------------------------------------------------
package npt_pkg;

    // Number of mapping slots, one cell per slot.
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int PROTO_W     = 8;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0] RST_INNER_ADDR  = 32'hC0A8_1401;
    localparam logic [ADDR_W-1:0] RST_OUTER_ADDR  = 32'hC0A8_1E01;
    localparam logic [ADDR_W-1:0] RST_BLOCKED_A   = 32'h0A00_0202;
    localparam logic [ADDR_W-1:0] RST_BLOCKED_B   = 32'h0A00_020F;
    localparam logic [PORT_W-1:0] RST_FIRST_PORT  = 16'd10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        STS_OUT_FWD  = 3'd0,
        STS_IN_FWD   = 3'd1,
        STS_BLOCKED  = 3'd2,
        STS_NOT_UDP  = 3'd3,
        STS_NO_MAP   = 3'd4,
        STS_FULL     = 3'd5,
        STS_TO_INNER = 3'd6
    } t_status;

    // Direction of a packet, which decides what the cells do with the token.
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_OUT  = 2'd1,
        MODE_IN   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_DONE   = 2'd2
    } t_state;

    // Search token. For outbound packets hit marks a match or a fresh
    // allocation and slot records where. For inbound packets hit marks a
    // slot that is in use and the matching cell fills in the data fields.
    typedef struct packed {
        logic              valid;
        t_mode             mode;
        logic [ADDR_W-1:0] key_addr;
        logic [PORT_W-1:0] key_port;
        logic [IDX_W-1:0]  slot;
        logic              hit;
        logic              alloc;
        logic [ADDR_W-1:0] data_addr;
        logic [PORT_W-1:0] data_port;
    } t_token;

endpackage
`default_nettype wire

[src/npt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAT port translator mapping cell
// Holds one mapping slot and passes the search token on to the next cell.
// ----------------------------------------------------------------------------
module npt_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [npt_pkg::IDX_W-1:0]  i_index,
    input  wire logic [npt_pkg::CNT_W-1:0]  i_used,
    input  wire npt_pkg::t_token            i_tok,
    output npt_pkg::t_token                 o_tok
);

    logic [npt_pkg::ADDR_W-1:0] r_addr;
    logic [npt_pkg::PORT_W-1:0] r_port;
    npt_pkg::t_token            r_tok;
    npt_pkg::t_token            n_tok;
    logic                       n_wr;
    logic                       in_use;
    logic                       at_free;
    logic                       key_match;

    assign in_use    = npt_pkg::CNT_W'(i_index) < i_used;
    assign at_free   = npt_pkg::CNT_W'(i_index) == i_used;
    assign key_match = (r_addr == i_tok.key_addr) && (r_port == i_tok.key_port);

    always_comb begin
        n_tok = i_tok;
        n_wr  = 1'b0;
        if (i_tok.valid) begin
            unique case (i_tok.mode)
                npt_pkg::MODE_OUT: begin
                    if (in_use) begin
                        if (!i_tok.hit && key_match) begin
                            n_tok.hit  = 1'b1;
                            n_tok.slot = i_index;
                        end
                    end else if (at_free && !i_tok.hit) begin
                        // First free slot and no match before it: claim it.
                        n_wr        = 1'b1;
                        n_tok.hit   = 1'b1;
                        n_tok.alloc = 1'b1;
                        n_tok.slot  = i_index;
                    end
                end
                npt_pkg::MODE_IN: begin
                    if (i_tok.hit && (i_tok.slot == i_index)) begin
                        n_tok.data_addr = r_addr;
                        n_tok.data_port = r_port;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_addr <= i_tok.key_addr;
            r_port <= i_tok.key_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[src/npt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAT port translator control
// Configuration registers, packet classification, token launch and result.
// ----------------------------------------------------------------------------
module npt_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [npt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [npt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [npt_pkg::ADDR_W-1:0]     i_src_addr,
    input  wire logic [npt_pkg::PORT_W-1:0]     i_src_port,
    input  wire logic [npt_pkg::ADDR_W-1:0]     i_dst_addr,
    input  wire logic [npt_pkg::PORT_W-1:0]     i_dst_port,
    input  wire logic [npt_pkg::PROTO_W-1:0]    i_protocol,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [npt_pkg::ADDR_W-1:0]          o_new_src_addr,
    output logic [npt_pkg::PORT_W-1:0]          o_new_src_port,
    output logic [npt_pkg::ADDR_W-1:0]          o_new_dst_addr,
    output logic [npt_pkg::PORT_W-1:0]          o_new_dst_port,
    output logic [npt_pkg::STATUS_W-1:0]        o_status,
    output npt_pkg::t_token                     o_tok,
    output logic [npt_pkg::CNT_W-1:0]           o_used,
    input  wire npt_pkg::t_token                i_tok
);

    // Configuration.
    logic [npt_pkg::ADDR_W-1:0] r_inner_addr;
    logic [npt_pkg::ADDR_W-1:0] r_outer_addr;
    logic [npt_pkg::ADDR_W-1:0] r_blocked_a;
    logic [npt_pkg::ADDR_W-1:0] r_blocked_b;
    logic [npt_pkg::PORT_W-1:0] r_first_port;

    npt_pkg::t_state            r_state;
    npt_pkg::t_state            n_state;
    logic [npt_pkg::CNT_W-1:0]  r_used;

    // Packet held while its token travels.
    logic [npt_pkg::ADDR_W-1:0]  r_src_addr;
    logic [npt_pkg::PORT_W-1:0]  r_src_port;
    logic [npt_pkg::ADDR_W-1:0]  r_dst_addr;
    logic [npt_pkg::PORT_W-1:0]  r_dst_port;
    logic [npt_pkg::PROTO_W-1:0] r_protocol;
    npt_pkg::t_mode              r_mode;

    npt_pkg::t_token            r_launch;
    npt_pkg::t_token            n_launch;
    npt_pkg::t_token            r_fin;

    logic                       r_out_valid;
    logic [npt_pkg::ADDR_W-1:0] r_new_src_addr;
    logic [npt_pkg::PORT_W-1:0] r_new_src_port;
    logic [npt_pkg::ADDR_W-1:0] r_new_dst_addr;
    logic [npt_pkg::PORT_W-1:0] r_new_dst_port;
    npt_pkg::t_status           r_status;

    logic                       in_accept;
    logic                       out_free;
    logic                       load_out;
    npt_pkg::t_mode             in_mode;
    logic [npt_pkg::PORT_W-1:0] in_slot;
    logic                       in_slot_used;

    logic [npt_pkg::ADDR_W-1:0] res_src_addr;
    logic [npt_pkg::PORT_W-1:0] res_src_port;
    logic [npt_pkg::ADDR_W-1:0] res_dst_addr;
    logic [npt_pkg::PORT_W-1:0] res_dst_port;
    npt_pkg::t_status           res_base;
    npt_pkg::t_status           res_fail;
    logic                       res_failed;
    npt_pkg::t_status           res_status;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign load_out  = (r_state == npt_pkg::ST_DONE) && out_free;

    // Classification of an arriving packet.
    assign in_slot      = i_dst_port - r_first_port;
    assign in_slot_used = 32'(in_slot) < 32'(r_used);

    always_comb begin
        if ((i_dst_addr != r_inner_addr) && (i_dst_addr != r_outer_addr)) begin
            in_mode = npt_pkg::MODE_OUT;
        end else if (i_dst_addr == r_outer_addr) begin
            in_mode = npt_pkg::MODE_IN;
        end else begin
            in_mode = npt_pkg::MODE_NONE;
        end
    end

    always_comb begin
        n_launch           = r_launch;
        n_launch.valid     = in_accept;
        if (in_accept) begin
            n_launch.mode      = in_mode;
            n_launch.key_addr  = i_src_addr;
            n_launch.key_port  = i_src_port;
            n_launch.slot      = in_slot[npt_pkg::IDX_W-1:0];
            n_launch.hit       = (in_mode == npt_pkg::MODE_IN) && in_slot_used;
            n_launch.alloc     = 1'b0;
            n_launch.data_addr = i_dst_addr;
            n_launch.data_port = i_dst_port;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = npt_pkg::ST_SEARCH;
                end
            end
            npt_pkg::ST_SEARCH: begin
                if (i_tok.valid) begin
                    n_state = npt_pkg::ST_DONE;
                end
            end
            npt_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = npt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_in_stall = (r_state != npt_pkg::ST_IDLE);
    end

    // Result of a finished search.
    always_comb begin
        res_src_addr = r_src_addr;
        res_src_port = r_src_port;
        res_dst_addr = r_dst_addr;
        res_dst_port = r_dst_port;
        res_failed   = 1'b0;
        res_fail     = npt_pkg::STS_TO_INNER;
        unique case (r_mode)
            npt_pkg::MODE_OUT: begin
                res_base = npt_pkg::STS_OUT_FWD;
                if (r_fin.hit) begin
                    res_src_addr = r_outer_addr;
                    res_src_port = r_first_port + npt_pkg::PORT_W'(r_fin.slot);
                end else begin
                    res_failed = 1'b1;
                    res_fail   = npt_pkg::STS_FULL;
                end
            end
            npt_pkg::MODE_IN: begin
                res_base = npt_pkg::STS_IN_FWD;
                if (r_fin.hit) begin
                    res_dst_addr = r_fin.data_addr;
                    res_dst_port = r_fin.data_port;
                end else begin
                    res_failed = 1'b1;
                    res_fail   = npt_pkg::STS_NO_MAP;
                end
            end
            default: begin
                res_base   = npt_pkg::STS_TO_INNER;
                res_failed = 1'b1;
                res_fail   = npt_pkg::STS_TO_INNER;
            end
        endcase
    end

    always_comb begin
        priority if (r_protocol != npt_pkg::PROTO_UDP) begin
            res_status = npt_pkg::STS_NOT_UDP;
        end else if ((r_src_addr == r_blocked_a) || (r_src_addr == r_blocked_b)) begin
            res_status = npt_pkg::STS_BLOCKED;
        end else if (res_failed) begin
            res_status = res_fail;
        end else begin
            res_status = res_base;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= npt_pkg::ST_IDLE;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
            r_launch.valid <= 1'b0;
            r_inner_addr <= npt_pkg::RST_INNER_ADDR;
            r_outer_addr <= npt_pkg::RST_OUTER_ADDR;
            r_blocked_a  <= npt_pkg::RST_BLOCKED_A;
            r_blocked_b  <= npt_pkg::RST_BLOCKED_B;
            r_first_port <= npt_pkg::RST_FIRST_PORT;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (load_out && r_fin.alloc) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    npt_pkg::CFG_INNER_ADDR: r_inner_addr <= i_cfg_data;
                    npt_pkg::CFG_OUTER_ADDR: r_outer_addr <= i_cfg_data;
                    npt_pkg::CFG_BLOCKED_A:  r_blocked_a  <= i_cfg_data;
                    npt_pkg::CFG_BLOCKED_B:  r_blocked_b  <= i_cfg_data;
                    npt_pkg::CFG_FIRST_PORT: r_first_port <= i_cfg_data[npt_pkg::PORT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_src_addr <= i_src_addr;
            r_src_port <= i_src_port;
            r_dst_addr <= i_dst_addr;
            r_dst_port <= i_dst_port;
            r_protocol <= i_protocol;
            r_mode     <= in_mode;
        end
        if ((r_state == npt_pkg::ST_SEARCH) && i_tok.valid) begin
            r_fin <= i_tok;
        end
        if (load_out) begin
            r_new_src_addr <= res_src_addr;
            r_new_src_port <= res_src_port;
            r_new_dst_addr <= res_dst_addr;
            r_new_dst_port <= res_dst_port;
            r_status       <= res_status;
        end
    end

    assign o_tok          = r_launch;
    assign o_used         = r_used;
    assign o_out_valid    = r_out_valid;
    assign o_new_src_addr = r_new_src_addr;
    assign o_new_src_port = r_new_src_port;
    assign o_new_dst_addr = r_new_dst_addr;
    assign o_new_dst_port = r_new_dst_port;
    assign o_status       = r_status;

    // A token leaves the chain only while its packet is being searched.
    a_tok_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok.valid |-> (r_state == npt_pkg::ST_SEARCH))
        else $error("search token left the chain outside a search");

    // The slot count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= npt_pkg::TABLE_DEPTH)
        else $error("slot count above table size");

    // The slot count only grows by one, and only when a result is loaded.
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != $past(r_used)) |->
            ((r_used == $past(r_used) + 1'b1) && $past(load_out)))
        else $error("slot count changed unexpectedly");

    // A loaded result is presented on the output as the control returns to idle.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out) |=> (o_out_valid && (r_state == npt_pkg::ST_IDLE)))
        else $error("result load did not present a transfer");

endmodule
`default_nettype wire

[src/nat_port_translator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NAT port translator
// Source port translation for outbound packets and reverse lookup for inbound
// packets, with a mapping table held in a row of cells.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   cfg     | in        | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//   in      | in        | i_in_valid / o_in_stall   | src/dst addr+port, protocol
//   out     | out       | o_out_valid / i_out_stall | new src/dst addr+port, status
//
// Every packet's search token passes the launch register, the output
// register of each cell and the finish register before the result is
// registered: it walks the whole cell chain, one cell per cycle, whatever
// the direction of the packet. No new packet is taken during a search.
// The next packet is taken as soon as the previous result has been loaded
// into the result registers, even while it still waits on the output.
// Reset is synchronous and active low; it empties the table (slot count zero)
// and restores the configuration registers; the cell contents are not cleared.
// A stalled output holds its result; a further finished search waits for it.
// ----------------------------------------------------------------------------
module nat_port_translator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [npt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [npt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [npt_pkg::ADDR_W-1:0]     i_src_addr,
    input  wire logic [npt_pkg::PORT_W-1:0]     i_src_port,
    input  wire logic [npt_pkg::ADDR_W-1:0]     i_dst_addr,
    input  wire logic [npt_pkg::PORT_W-1:0]     i_dst_port,
    input  wire logic [npt_pkg::PROTO_W-1:0]    i_protocol,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [npt_pkg::ADDR_W-1:0]          o_new_src_addr,
    output logic [npt_pkg::PORT_W-1:0]          o_new_src_port,
    output logic [npt_pkg::ADDR_W-1:0]          o_new_dst_addr,
    output logic [npt_pkg::PORT_W-1:0]          o_new_dst_port,
    output logic [npt_pkg::STATUS_W-1:0]        o_status
);

    // Token positions along the chain: entry 0 is launched by the control
    // block, entry k+1 is the output register of cell k, and the last entry
    // returns to the control block.
    npt_pkg::t_token                 w_tok [npt_pkg::TABLE_DEPTH+1];
    logic [npt_pkg::CNT_W-1:0]       w_used;

    // The control block classifies each packet as it is transferred in. An
    // outbound packet sends its source address and port down the chain; each
    // cell below the slot count compares them with its mapping, and the first
    // free cell claims the slot if nothing matched before it. An inbound packet
    // carries the slot derived from its destination port, and the cell of that
    // slot copies out the private address and port. Packets to the inner router
    // address still walk the chain but nothing touches them.
    npt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_src_addr     (i_src_addr),
        .i_src_port     (i_src_port),
        .i_dst_addr     (i_dst_addr),
        .i_dst_port     (i_dst_port),
        .i_protocol     (i_protocol),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_new_src_addr (o_new_src_addr),
        .o_new_src_port (o_new_src_port),
        .o_new_dst_addr (o_new_dst_addr),
        .o_new_dst_port (o_new_dst_port),
        .o_status       (o_status),
        .o_tok          (w_tok[0]),
        .o_used         (w_used),
        .i_tok          (w_tok[npt_pkg::TABLE_DEPTH])
    );

    // One cell per slot; each cell learns its own slot number from its place
    // in the row.
    for (genvar k = 0; k < npt_pkg::TABLE_DEPTH; k++) begin : g_cell
        npt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (npt_pkg::IDX_W'(k)),
            .i_used  (w_used),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

endmodule
`default_nettype wire
